### rtl/frkt_pkg.sv
package frkt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int KEY_BITS_DEF    = 32;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 4;
  localparam int OCC_W  = 5;
  localparam int CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  localparam int SLOT_W_DEF = $clog2(TABLE_DEPTH_DEF);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_MISSING  = 2'd2,
    ST_DEFERRED = 2'd3
  } status_t;

  typedef struct packed {
    logic                    active;
    logic [KEY_BITS_DEF-1:0] key;
    logic                    hit;
    logic [SLOT_W_DEF-1:0]   hit_slot;
    logic [SLOT_W_DEF-1:0]   hit_rank;
    logic                    free_found;
    logic [SLOT_W_DEF-1:0]   free_slot;
    logic                    old_found;
    logic [SLOT_W_DEF-1:0]   old_slot;
    logic [KEY_BITS_DEF-1:0] old_key;
  } carry_def_t;

  typedef struct packed {
    logic                    clear_all;
    logic                    remove_en;
    logic [SLOT_W_DEF-1:0]   remove_slot;
    logic [SLOT_W_DEF-1:0]   remove_rank;
    logic                    write_en;
    logic [SLOT_W_DEF-1:0]   write_slot;
    logic [KEY_BITS_DEF-1:0] write_key;
    logic [SLOT_W_DEF-1:0]   write_rank;
  } cmd_def_t;

endpackage

### rtl/frkt_if.sv
interface frkt_in_if;
  import frkt_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [KEY_W-1:0] key;
  logic             busy_req;

  modport source (output valid, operation, key, busy_req, input ready);
  modport sink (input valid, operation, key, busy_req, output ready);
endinterface

interface frkt_out_if;
  import frkt_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic [1:0]        status;
  logic              evicted;
  logic [KEY_W-1:0]  evicted_key;
  logic [OCC_W-1:0]  occupancy;

  modport source (
    output valid, found, slot, status, evicted, evicted_key, occupancy,
    input ready
  );
  modport sink (
    input valid, found, slot, status, evicted, evicted_key, occupancy,
    output ready
  );
endinterface

### rtl/frkt_cell.sv
module frkt_cell #(
  parameter int  TABLE_DEPTH = frkt_pkg::TABLE_DEPTH_DEF,
  parameter int  KEY_BITS    = frkt_pkg::KEY_BITS_DEF,
  parameter int  IDX         = 0,
  parameter type carry_t     = frkt_pkg::carry_def_t,
  parameter type cmd_t       = frkt_pkg::cmd_def_t
) (
  input  logic   clk,
  input  logic   rst_n,
  input  carry_t carry_in,
  output carry_t carry_out,
  input  cmd_t   cmd
);

  localparam int RANK_W = $clog2(TABLE_DEPTH);
  localparam logic [RANK_W-1:0] MY_SLOT = RANK_W'(IDX);

  logic                valid_r, valid_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic                active_r;
  carry_t              carry_r, carry_nxt;

  always_comb begin
    carry_nxt = carry_in;
    if (valid_r && key_r == carry_in.key && !carry_in.hit) begin
      carry_nxt.hit      = 1'b1;
      carry_nxt.hit_slot = MY_SLOT;
      carry_nxt.hit_rank = rank_r;
    end
    if (!valid_r && !carry_in.free_found) begin
      carry_nxt.free_found = 1'b1;
      carry_nxt.free_slot  = MY_SLOT;
    end
    if (valid_r && rank_r == '0 && !carry_in.old_found) begin
      carry_nxt.old_found = 1'b1;
      carry_nxt.old_slot  = MY_SLOT;
      carry_nxt.old_key   = key_r;
    end
  end

  always_comb begin
    carry_out        = carry_r;
    carry_out.active = active_r;
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    rank_nxt  = rank_r;
    if (cmd.clear_all) begin
      valid_nxt = 1'b0;
    end else if (cmd.write_en && cmd.write_slot == MY_SLOT) begin
      valid_nxt = 1'b1;
      key_nxt   = cmd.write_key;
      rank_nxt  = cmd.write_rank;
    end else if (cmd.remove_en && valid_r) begin
      if (cmd.remove_slot == MY_SLOT) begin
        valid_nxt = 1'b0;
      end else if (rank_r > cmd.remove_rank) begin
        rank_nxt = rank_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      active_r <= carry_nxt.active;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    rank_r  <= rank_nxt;
    carry_r <= carry_nxt;
  end

endmodule

### rtl/fifo_replacement_key_table.sv
// Each key scans the cell chain, then commits its table update and registers its result.
// A new item waits until the last one commits; the key scan walks the cell
// chain one cell per cycle, and a stalled result delays the table update.
// The next item is accepted while a finished result still waits in the output register.
// Synchronous active-low reset empties the table and sets capacity to 16.
module fifo_replacement_key_table #(
  parameter int TABLE_DEPTH = frkt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = frkt_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [frkt_pkg::CAP_W-1:0] cfg_wdata,
  frkt_in_if.sink                    in_if,
  frkt_out_if.source                 out_if
);

  import frkt_pkg::*;

  localparam int RANK_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef struct packed {
    logic                active;
    logic [KEY_BITS-1:0] key;
    logic                hit;
    logic [RANK_W-1:0]   hit_slot;
    logic [RANK_W-1:0]   hit_rank;
    logic                free_found;
    logic [RANK_W-1:0]   free_slot;
    logic                old_found;
    logic [RANK_W-1:0]   old_slot;
    logic [KEY_BITS-1:0] old_key;
  } carry_t;

  typedef struct packed {
    logic                clear_all;
    logic                remove_en;
    logic [RANK_W-1:0]   remove_slot;
    logic [RANK_W-1:0]   remove_rank;
    logic                write_en;
    logic [RANK_W-1:0]   write_slot;
    logic [KEY_BITS-1:0] write_key;
    logic [RANK_W-1:0]   write_rank;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  op_t                op_r;
  logic               busy_r;
  carry_t             res_r;
  carry_t             chain [TABLE_DEPTH+1];
  cmd_t               dec_cmd, cmd;

  logic               out_valid_r;
  logic               found_r, found_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  status_t            status_r, status_nxt;
  logic               evicted_r, evicted_nxt;
  logic [KEY_W-1:0]   evkey_r, evkey_nxt;
  logic [OCC_W-1:0]   occ_r;

  logic               in_accept;
  logic               commit;
  logic [CMP_W-1:0]   cap_ext, cap_eff, cnt_ext, depth_c;
  logic               evict;
  logic [CNT_W-1:0]   cnt_mid;
  logic [RANK_W-1:0]  new_slot;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign commit      = (state_r == S_COMMIT) && (!out_valid_r || out_if.ready);

  always_comb begin
    chain[0]        = '0;
    chain[0].active = in_accept;
    chain[0].key    = KEY_BITS'(in_if.key);
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    frkt_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS),
      .IDX         (i),
      .carry_t     (carry_t),
      .cmd_t       (cmd_t)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .carry_in  (chain[i]),
      .carry_out (chain[i+1]),
      .cmd       (cmd)
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (chain[TABLE_DEPTH].active) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cap_ext  = CMP_W'(cap_r);
    depth_c  = CMP_W'(TABLE_DEPTH);
    cnt_ext  = CMP_W'(count_r);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > depth_c) begin
      cap_eff = depth_c;
    end else begin
      cap_eff = cap_ext;
    end
    evict   = (cnt_ext >= cap_eff) && (count_r != '0);
    cnt_mid = evict ? count_r - 1'b1 : count_r;
    if (evict && (!res_r.free_found || res_r.old_slot < res_r.free_slot)) begin
      new_slot = res_r.old_slot;
    end else begin
      new_slot = res_r.free_slot;
    end

    dec_cmd     = '0;
    count_nxt   = count_r;
    found_nxt   = 1'b0;
    slot_nxt    = '0;
    status_nxt  = ST_OK;
    evicted_nxt = 1'b0;
    evkey_nxt   = '0;

    case (op_r)
      OP_LOOKUP: begin
        if (res_r.hit) begin
          found_nxt = 1'b1;
          slot_nxt  = SLOT_W'(res_r.hit_slot);
        end else begin
          status_nxt = ST_MISSING;
        end
      end
      OP_INSERT: begin
        if (res_r.hit) begin
          found_nxt  = 1'b1;
          slot_nxt   = SLOT_W'(res_r.hit_slot);
          status_nxt = ST_PRESENT;
        end else begin
          dec_cmd.remove_en   = evict;
          dec_cmd.remove_slot = res_r.old_slot;
          dec_cmd.remove_rank = '0;
          dec_cmd.write_en    = 1'b1;
          dec_cmd.write_slot  = new_slot;
          dec_cmd.write_key   = res_r.key;
          dec_cmd.write_rank  = RANK_W'(cnt_mid);
          count_nxt           = cnt_mid + 1'b1;
          slot_nxt            = SLOT_W'(new_slot);
          evicted_nxt         = evict;
          evkey_nxt           = evict ? KEY_W'(res_r.old_key) : '0;
        end
      end
      OP_DELETE: begin
        if (!res_r.hit) begin
          status_nxt = ST_MISSING;
        end else begin
          found_nxt = 1'b1;
          if (busy_r) begin
            status_nxt = ST_DEFERRED;
          end else begin
            dec_cmd.remove_en   = 1'b1;
            dec_cmd.remove_slot = res_r.hit_slot;
            dec_cmd.remove_rank = res_r.hit_rank;
            count_nxt           = count_r - 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        dec_cmd.clear_all = 1'b1;
        count_nxt         = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase

    cmd = commit ? dec_cmd : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAPACITY_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= op_t'(in_if.operation);
      busy_r <= in_if.busy_req;
    end
    if (state_r == S_SCAN && chain[TABLE_DEPTH].active) begin
      res_r <= chain[TABLE_DEPTH];
    end
    if (commit) begin
      found_r   <= found_nxt;
      slot_r    <= slot_nxt;
      status_r  <= status_nxt;
      evicted_r <= evicted_nxt;
      evkey_r   <= evkey_nxt;
      occ_r     <= OCC_W'(count_nxt);
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.found       = found_r;
  assign out_if.slot        = slot_r;
  assign out_if.status      = status_r;
  assign out_if.evicted     = evicted_r;
  assign out_if.evicted_key = evkey_r;
  assign out_if.occupancy   = occ_r;

endmodule

### rtl/frkt_checker.sv
module frkt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic [frkt_pkg::SLOT_W-1:0] out_slot,
  input logic [1:0]                  out_status,
  input logic                        out_evicted,
  input logic [frkt_pkg::KEY_W-1:0]  out_evicted_key,
  input logic [frkt_pkg::OCC_W-1:0]  out_occupancy
);

  import frkt_pkg::*;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is still being worked on");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_slot)
      && $stable(out_status) && $stable(out_evicted) && $stable(out_evicted_key)
      && $stable(out_occupancy))
    else $error("stalled result changed or vanished");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_deferred: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DEFERRED |-> out_found && !out_evicted)
    else $error("deferred deletion reported for an absent key or with eviction");

endmodule

bind fifo_replacement_key_table frkt_checker u_frkt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_found       (out_if.found),
  .out_slot        (out_if.slot),
  .out_status      (out_if.status),
  .out_evicted     (out_if.evicted),
  .out_evicted_key (out_if.evicted_key),
  .out_occupancy   (out_if.occupancy)
);

### verif/tb_fifo_replacement_key_table.sv
`timescale 1ns / 1ps

module tb_fifo_replacement_key_table;
  import frkt_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 113;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int STEADY_PHASE = 5;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [OCC_W-1:0]  occupancy;
  } reply_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic             busy;
    logic             typed;
    reply_t           want;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  frkt_in_if  in_ch ();
  frkt_out_if out_ch ();

  fifo_replacement_key_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  logic             slot_used [DEPTH];
  logic [KEY_W-1:0] slot_key  [DEPTH];
  int               slot_age  [DEPTH];
  int               used_count;
  logic [CAP_W-1:0] capacity_reg;

  reply_t           awaited_replies[$];
  row_t             opening_rows[$];
  logic [KEY_W-1:0] key_pool[$];
  reply_t           no_reply;

  int  mismatches;
  int  items_sent;
  int  replies_seen;
  int  evictions_seen;
  int  deferrals_seen;
  int  capacity_writes;
  bit  steady;
  bit  held;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("fifo_replacement_key_table verification failed");
    $finish;
  end

  function automatic void clear_model();
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_age[i]  = 0;
    end
    used_count = 0;
  endfunction

  function automatic void drop_slot(int s);
    slot_used[s] = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && slot_age[i] > slot_age[s]) begin
        slot_age[i]--;
      end
    end
    if (used_count > 0) begin
      used_count--;
    end
  endfunction

  function automatic reply_t key_table_step(op_t op, logic [KEY_W-1:0] k, logic busy);
    reply_t r;
    int     hit;
    int     fr;
    int     cap;
    r   = '0;
    hit = -1;
    fr  = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == k) begin
        hit = i;
      end
    end
    case (op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r.found = 1'b1;
          r.slot  = SLOT_W'(hit);
        end else begin
          r.status = ST_MISSING;
        end
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          r.found  = 1'b1;
          r.slot   = SLOT_W'(hit);
          r.status = ST_PRESENT;
        end else begin
          cap = int'(capacity_reg);
          if (cap == 0) begin
            cap = 1;
          end
          if (cap > DEPTH) begin
            cap = DEPTH;
          end
          if (used_count >= cap && used_count > 0) begin
            for (int i = 0; i < DEPTH; i++) begin
              if (!r.evicted && slot_used[i] && slot_age[i] == 0) begin
                r.evicted     = 1'b1;
                r.evicted_key = slot_key[i];
                drop_slot(i);
              end
            end
          end
          for (int i = 0; i < DEPTH; i++) begin
            if (fr < 0 && !slot_used[i]) begin
              fr = i;
            end
          end
          if (fr >= 0) begin
            slot_used[fr] = 1'b1;
            slot_key[fr]  = k;
            slot_age[fr]  = used_count;
            used_count++;
            r.slot = SLOT_W'(fr);
          end
        end
      end
      OP_DELETE: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          r.found = 1'b1;
          if (busy) begin
            r.status = ST_DEFERRED;
          end else begin
            drop_slot(hit);
          end
        end
      end
      default: begin
        clear_model();
      end
    endcase
    r.occupancy = OCC_W'(used_count);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("MISMATCH reply %0d field %s: got 0x%0h, expected 0x%0h",
             replies_seen, field, got, want);
    mismatches++;
  endtask

  task automatic check_reply();
    reply_t w;
    if (awaited_replies.size() == 0) begin
      report_mismatch("unexpected item", 32'(out_ch.occupancy), '0);
    end else begin
      w = awaited_replies[0];
      awaited_replies.delete(0);
      if (out_ch.found !== w.found) report_mismatch("found", 32'(out_ch.found), 32'(w.found));
      if (out_ch.slot !== w.slot) report_mismatch("slot", 32'(out_ch.slot), 32'(w.slot));
      if (out_ch.status !== w.status) begin
        report_mismatch("status", 32'(out_ch.status), 32'(w.status));
      end
      if (out_ch.evicted !== w.evicted) begin
        report_mismatch("evicted", 32'(out_ch.evicted), 32'(w.evicted));
      end
      if (out_ch.evicted_key !== w.evicted_key) begin
        report_mismatch("evicted_key", out_ch.evicted_key, w.evicted_key);
      end
      if (out_ch.occupancy !== w.occupancy) begin
        report_mismatch("occupancy", 32'(out_ch.occupancy), 32'(w.occupancy));
      end
      if (w.evicted) evictions_seen++;
      if (w.status == ST_DEFERRED) deferrals_seen++;
    end
    replies_seen++;
  endtask

  initial begin : result_side
    int stall;
    out_ch.ready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!steady && $urandom_range(99) < 17) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        check_reply();
      end
      if (!held && replies_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        stall = 0;
        while (stall < HOLD_CYCLES) begin
          @(posedge clk);
          stall++;
        end
      end
    end
  end

  task automatic offer_item(op_t op, logic [KEY_W-1:0] k, logic b, logic typed, reply_t want);
    reply_t r;
    if (!steady && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= k;
    in_ch.busy_req  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = key_table_step(op, k, b);
    awaited_replies.insert(awaited_replies.size(), typed ? want : r);
    items_sent++;
  endtask

  task automatic settle_table();
    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_reg = value;
    capacity_writes++;
  endtask

  task automatic add_row(op_t op, logic [KEY_W-1:0] k, logic b, logic typed,
                         logic found, int slot, status_t st, int occ);
    row_t row;
    row.op                = op;
    row.key               = k;
    row.busy              = b;
    row.typed             = typed;
    row.want              = '0;
    row.want.found        = found;
    row.want.slot         = SLOT_W'(slot);
    row.want.status       = st;
    row.want.occupancy    = OCC_W'(occ);
    opening_rows.insert(opening_rows.size(), row);
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] caps [PHASES];
    row_t             row;
    int               pick;
    op_t              op;
    logic [KEY_W-1:0] k;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOOKUP;
    in_ch.key       <= '0;
    in_ch.busy_req  <= 1'b0;
    no_reply        = '0;
    mismatches      = 0;
    items_sent      = 0;
    replies_seen    = 0;
    evictions_seen  = 0;
    deferrals_seen  = 0;
    capacity_writes = 0;
    steady          = 1'b0;
    capacity_reg    = CAPACITY_RESET;
    clear_model();

    caps[0] = 5'd3;
    caps[1] = 5'd0;
    caps[2] = 5'd1;
    caps[3] = 5'd31;
    caps[4] = 5'd17;
    caps[5] = 5'd16;
    caps[6] = 5'd2;
    caps[7] = 5'd9;
    caps[8] = CAP_W'($urandom_range(0, 31));
    caps[9] = CAP_W'($urandom_range(1, 16));

    add_row(OP_LOOKUP, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 0, ST_MISSING, 0);
    add_row(OP_DELETE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 0, ST_MISSING, 0);
    add_row(OP_CLEAR, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 0, ST_OK, 0);
    add_row(OP_INSERT, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 0, ST_OK, 1);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1, ST_OK, 2);
    add_row(OP_INSERT, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 0, ST_PRESENT, 2);
    add_row(OP_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1, ST_OK, 2);
    add_row(OP_DELETE, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 0, ST_DEFERRED, 2);
    add_row(OP_DELETE, 32'h0000_0000, 1'b0, 1'b1, 1'b1, 0, ST_OK, 1);
    add_row(OP_INSERT, 32'hA5A5_A5A5, 1'b0, 1'b1, 1'b0, 0, ST_OK, 2);
    for (int i = 0; i < 14; i++) begin
      add_row(OP_INSERT, 32'h1357_0000 + 32'(i) * 32'h0101_0001, 1'(i), 1'b0,
              1'b0, 0, ST_OK, 0);
    end
    add_row(OP_INSERT, 32'h7FFF_FFFE, 1'b0, 1'b0, 1'b0, 0, ST_OK, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[i]) begin
      row = opening_rows[i];
      offer_item(row.op, row.key, row.busy, row.typed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_table();
      write_capacity(caps[ph]);
      steady = (ph == STEADY_PHASE);
      key_pool.delete();
      key_pool.insert(key_pool.size(), 32'h0000_0000);
      key_pool.insert(key_pool.size(), 32'hFFFF_FFFF);
      repeat ($urandom_range(2, 22)) key_pool.insert(key_pool.size(), $urandom);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          op = OP_INSERT;
        end else if (pick < 65) begin
          op = OP_LOOKUP;
        end else if (pick < 95) begin
          op = OP_DELETE;
        end else begin
          op = OP_CLEAR;
        end
        if ($urandom_range(99) < 90) begin
          k = key_pool[$urandom_range(key_pool.size() - 1)];
        end else begin
          k = $urandom;
        end
        offer_item(op, k, 1'($urandom_range(1)), 1'b0, no_reply);
      end
    end
    steady = 1'b0;

    settle_table();
    repeat (40) @(posedge clk);
    $display("Sent %0d items and checked %0d replies across %0d capacity settings.",
             items_sent, replies_seen, capacity_writes + 1);
    $display("Replies included %0d evictions and %0d deferred deletions; %0d mismatches.",
             evictions_seen, deferrals_seen, mismatches);
    if (mismatches == 0) begin
      $display("fifo_replacement_key_table verification clean");
    end else begin
      $display("fifo_replacement_key_table verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/frkt_pkg.sv
rtl/frkt_if.sv
rtl/frkt_cell.sv
rtl/fifo_replacement_key_table.sv
rtl/frkt_checker.sv
verif/tb_fifo_replacement_key_table.sv
